/* rtl/core/assert_macros.svh */
// Assertion macros shared by the fault log RTL.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond in a cycle implies prop in the same cycle
`define ASSERT_SAME_CYCLE(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

// cond in a cycle implies prop in the next cycle
`define ASSERT_NEXT_CYCLE(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

/* rtl/core/flt_pkg.sv */
// Fault log package: constants, opcodes and shared structs.
// No dependencies.
`default_nettype none

package flt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam logic [31:0] STAMP_MAX        = 32'hFFFF_FFFF;
  localparam logic [7:0]  SYSTEM_CHANNEL   = 8'hFF;
  localparam logic [31:0] TIMEOUT_RST      = 32'd1000;
  localparam logic [7:0]  TIMEOUT_CODE_RST = 8'd1;

  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_CLEAR     = 3'd1;
  localparam logic [2:0] OP_QUERY     = 3'd2;
  localparam logic [2:0] OP_HEARTBEAT = 3'd3;
  localparam logic [2:0] OP_CHECK     = 3'd4;

  localparam logic [1:0] FAN_NONE    = 2'd0;
  localparam logic [1:0] FAN_FORCE   = 2'd1;
  localparam logic [1:0] FAN_RELEASE = 2'd2;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_CODE    = 1'b1;

  typedef struct packed {
    logic [7:0]  code;
    logic [7:0]  chan;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic code_eq;
    logic chan_eq;
    logic stamp_lt;
  } match_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } tbl_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/fault_log_table_with_heartbeat.sv */
// A set, or a check that declares the link lost, scans the table one entry per cycle through
// the single table read port and compare unit, then passes the write and done states; a clear,
// query or recovering heartbeat scans, then goes to the done state; others go straight to it.
// Throughput: one item at a time; the next is accepted the cycle after its result is loaded
// into the output register, which waits while an earlier result is stalled. Reset (rst,
// synchronous) clears active bits, link state, last heartbeat and config to defaults.
`default_nettype none

`include "assert_macros.svh"

module fault_log_table_with_heartbeat #(
  parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  fault_code,
  input  logic [7:0]  channel,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        present,
  output logic        evicted,
  output logic [5:0]  active_count,
  output logic        link_lost,
  output logic [1:0]  fan_action,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import flt_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [5:0] FULL_CNT = 6'(TABLE_ENTRIES);

  logic [31:0] timeout_ms;
  logic [7:0]  timeout_code;

  tbl_ctl_t          ctl;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  logic [TABLE_ENTRIES-1:0] active;
  logic [CntW-1:0]   count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_ms : {24'b0, timeout_code};

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms   <= TIMEOUT_RST;
      timeout_code <= TIMEOUT_CODE_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_TIMEOUT) begin
        timeout_ms <= pwdata;
      end else begin
        timeout_code <= pwdata[7:0];
      end
    end
  end

  flt_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data),
    .active  (active),
    .count   (count)
  );

  flt_seq #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .fault_code   (fault_code),
    .channel      (channel),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .present      (present),
    .evicted      (evicted),
    .active_count (active_count),
    .link_lost    (link_lost),
    .fan_action   (fan_action),
    .timeout_ms   (timeout_ms),
    .timeout_code (timeout_code),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data),
    .active       (active),
    .count        (count)
  );

  `ASSERT_NEXT_CYCLE(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_SAME_CYCLE(a_force_means_lost, clk, rst, out_valid && fan_action == FAN_FORCE, link_lost)
  `ASSERT_SAME_CYCLE(a_release_means_ok, clk, rst, out_valid && fan_action == FAN_RELEASE, !link_lost)
  `ASSERT_SAME_CYCLE(a_evict_when_full, clk, rst, out_valid && evicted, active_count == FULL_CNT && !present)

endmodule

`default_nettype wire

/* rtl/core/flt_table.sv */
// Fault entry store: code/channel/stamp memory with registered read,
// active bits and active counter. Depends on flt_pkg.
`default_nettype none

module flt_table #(
  parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  flt_pkg::tbl_ctl_t                  ctl,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
  input  flt_pkg::entry_t                    wr_data,
  output flt_pkg::entry_t                    rd_data,
  output logic [TABLE_ENTRIES-1:0]           active,
  output logic [$clog2(TABLE_ENTRIES+1)-1:0] count
);
  import flt_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // write marks the entry active, clear drops it; never both in one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      count  <= '0;
    end else if (ctl.wr_en) begin
      active[wr_addr] <= 1'b1;
      if (!active[wr_addr]) begin
        count <= count + 1'b1;
      end
    end else if (ctl.clr_en) begin
      active[wr_addr] <= 1'b0;
      if (active[wr_addr]) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/flt_cmp.sv */
// Shared compare unit: code, channel and stamp compare of one entry.
// Depends on flt_pkg.
`default_nettype none

module flt_cmp (
  input  flt_pkg::entry_t entry,
  input  logic [7:0]      key_code,
  input  logic [7:0]      key_chan,
  input  logic [31:0]     best,
  output flt_pkg::match_t match
);
  import flt_pkg::*;

  always_comb begin
    match.code_eq  = (entry.code == key_code);
    match.chan_eq  = (entry.chan == key_chan);
    match.stamp_lt = (entry.stamp < best);
  end

endmodule

`default_nettype wire

/* rtl/core/flt_seq.sv */
// Sequencer: takes an item, scans the table through the compare unit,
// writes back and holds the result register. Depends on flt_pkg, flt_cmp.
`default_nettype none

module flt_seq #(
  parameter int TABLE_ENTRIES = flt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         opcode,
  input  logic [7:0]                         fault_code,
  input  logic [7:0]                         channel,
  input  logic [31:0]                        now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               present,
  output logic                               evicted,
  output logic [5:0]                         active_count,
  output logic                               link_lost,
  output logic [1:0]                         fan_action,
  input  logic [31:0]                        timeout_ms,
  input  logic [7:0]                         timeout_code,
  output flt_pkg::tbl_ctl_t                  ctl,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
  output flt_pkg::entry_t                    wr_data,
  input  flt_pkg::entry_t                    rd_data,
  input  logic [TABLE_ENTRIES-1:0]           active,
  input  logic [$clog2(TABLE_ENTRIES+1)-1:0] count
);
  import flt_pkg::*;

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IdxW-1:0] LAST_IDX = IdxW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [1:0] M_SET   = 2'd0;
  localparam logic [1:0] M_CLEAR = 2'd1;
  localparam logic [1:0] M_QUERY = 2'd2;
  localparam logic [1:0] M_NONE  = 2'd3;

  logic [1:0]      state;
  logic [1:0]      mode;
  logic [7:0]      key_code;
  logic [7:0]      key_chan;
  logic [31:0]     stamp;
  logic [31:0]     last_hb;
  logic            lost;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] cmp_idx;
  logic [IdxW-1:0] free_idx;
  logic [IdxW-1:0] pick;
  logic            issuing;
  logic            cmp_vld;
  logic            hit;
  logic            free_found;
  logic            evict;
  logic [31:0]     best;
  logic [1:0]      fan;

  logic [31:0]      elapsed;
  logic             expired;
  match_t           m;
  logic             cur_act;
  logic             last_cmp;
  logic             take;
  logic [CntW+5:0]  cnt_ext;

  flt_cmp u_cmp (
    .entry    (rd_data),
    .key_code (key_code),
    .key_chan (key_chan),
    .best     (best),
    .match    (m)
  );

  assign elapsed  = now_ms - last_hb;
  assign expired  = (elapsed > timeout_ms);
  assign cur_act  = active[cmp_idx];
  assign last_cmp = cmp_vld && (cmp_idx == LAST_IDX);
  assign take     = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign cnt_ext  = {6'b0, count};

  always_comb begin
    ctl.rd_en  = (state == S_SCAN) && issuing;
    ctl.clr_en = (state == S_SCAN) && cmp_vld && (mode == M_CLEAR) && cur_act && m.code_eq;
    ctl.wr_en  = (state == S_WRITE) && !hit;
    rd_addr    = idx;
    wr_addr    = (state == S_WRITE) ? (free_found ? free_idx : pick) : cmp_idx;
    wr_data    = '{code: key_code, chan: key_chan, stamp: stamp};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lost      <= 1'b0;
      last_hb   <= '0;
      out_valid <= 1'b0;
      issuing   <= 1'b0;
      cmp_vld   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode       <= M_NONE;
            fan        <= FAN_NONE;
            hit        <= 1'b0;
            free_found <= 1'b0;
            evict      <= 1'b0;
            best       <= STAMP_MAX;
            pick       <= '0;
            idx        <= '0;
            issuing    <= 1'b1;
            cmp_vld    <= 1'b0;
            key_code   <= fault_code;
            key_chan   <= channel;
            stamp      <= now_ms;
            state      <= S_DONE;
            case (opcode)
              OP_SET: begin
                mode  <= M_SET;
                state <= S_SCAN;
              end
              OP_CLEAR: begin
                mode  <= M_CLEAR;
                state <= S_SCAN;
              end
              OP_QUERY: begin
                mode  <= M_QUERY;
                state <= S_SCAN;
              end
              OP_HEARTBEAT: begin
                last_hb <= now_ms;
                if (lost) begin
                  lost     <= 1'b0;
                  key_code <= timeout_code;
                  mode     <= M_CLEAR;
                  fan      <= FAN_RELEASE;
                  state    <= S_SCAN;
                end
              end
              OP_CHECK: begin
                if (expired && !lost) begin
                  lost     <= 1'b1;
                  key_code <= timeout_code;
                  key_chan <= SYSTEM_CHANNEL;
                  mode     <= M_SET;
                  fan      <= FAN_FORCE;
                  state    <= S_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // read issue runs one entry ahead of the compare
          cmp_vld <= issuing;
          cmp_idx <= idx;
          if (issuing) begin
            if (idx == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          if (cmp_vld) begin
            if (cur_act && m.code_eq && (mode == M_QUERY || (mode == M_SET && m.chan_eq))) begin
              hit <= 1'b1;
            end
            if (!cur_act && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cur_act && m.stamp_lt) begin
              best <= rd_data.stamp;
              pick <= cmp_idx;
            end
          end
          if (last_cmp) begin
            state <= (mode == M_SET) ? S_WRITE : S_DONE;
          end
        end
        S_WRITE: begin
          if (!hit && !free_found) begin
            evict <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (state == S_DONE && take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && take) begin
      present      <= hit;
      evicted      <= evict;
      active_count <= cnt_ext[5:0];
      link_lost    <= lost;
      fan_action   <= fan;
    end
  end

endmodule

`default_nettype wire
